FILE: hdl/per_client_memory_quota_table_top_macros.svh
// Assertion macros for the per-client memory quota table.
`ifndef PER_CLIENT_MEMORY_QUOTA_TABLE_TOP_MACROS_SVH
`define PER_CLIENT_MEMORY_QUOTA_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PCMQ_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("pcmq assertion failed");
`define PCMQ_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("pcmq assertion failed");
`else
`define PCMQ_ASSERT(lbl, expr)
`define PCMQ_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: hdl/pcmq_pkg.sv
// Shared types and constants of the per-client memory quota table.
package pcmq_pkg;
    localparam int ContextSlots = 64;
    localparam int ObjectSlots  = 1024;
    localparam int KeyW   = 30;
    localparam int OKeyW  = 62;
    localparam int RefW   = 16;
    localparam int ByteW  = 64;
    localparam int CtxW   = KeyW + RefW + ByteW;
    localparam int ObjW   = 1 + OKeyW + ByteW;
    localparam logic [RefW-1:0] RefMax = '1;

    typedef enum logic [2:0] {
        ACT_OPEN   = 3'd0,
        ACT_CLOSE  = 3'd1,
        ACT_CHARGE = 3'd2,
        ACT_COBJ   = 3'd3,
        ACT_UNCH   = 3'd4,
        ACT_UOBJ   = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_TRIAL     = 4'd1,
        ST_INVALID   = 4'd2,
        ST_CTX_FULL  = 4'd3,
        ST_OVERFLOW  = 4'd4,
        ST_QUOTA     = 4'd5,
        ST_OBJ_FULL  = 4'd6,
        ST_NOT_FOUND = 4'd7,
        ST_CLAMPED   = 4'd8
    } t_status;

    typedef struct packed {
        logic [ByteW-1:0] a;
        logic [ByteW-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ByteW-1:0] res;
        logic             cout;   // carry on add, borrow on subtract
    } t_alu_rsp;
endpackage

FILE: hdl/per_client_memory_quota_table_top.sv
// Per-client memory quota table: sequencer, context and object tables.
// After reset the object table is cleared one entry a cycle, and no request is accepted meanwhile.
// A request with a valid key is accepted, then scans the context table; a clearing last
// close, charge object or uncharge object then also scans the object table, and decode,
// arithmetic, write-back and response follow. Each scan reads the single read port of
// its table memory; requests are taken one at a time, and a response held by the receiver
// keeps the next response waiting.
`include "per_client_memory_quota_table_top_macros.svh"
module per_client_memory_quota_table_top #(
    parameter int CONTEXT_SLOTS = pcmq_pkg::ContextSlots,
    parameter int OBJECT_SLOTS  = pcmq_pkg::ObjectSlots
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic         i_cfg_wdata,    // clear_on_last_close
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [191:0] i_s_tdata,      // group_id[21:0] device_minor[30:22]
                                         // object_handle[62:31] amount[126:63] limit[190:127]
    input  logic [3:0]   i_s_tuser,      // action[2:0] trial_only[3]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,      // released_bytes[63:0] used_after[127:64]
    output logic [4:0]   o_m_tuser       // status[3:0] deny[4]
);
    localparam int CIW  = (CONTEXT_SLOTS > 1) ? $clog2(CONTEXT_SLOTS) : 1;
    localparam int OIW  = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
    localparam int MAXS = (CONTEXT_SLOTS > OBJECT_SLOTS) ? CONTEXT_SLOTS : OBJECT_SLOTS;
    localparam int SW   = $clog2(MAXS + 1);
    localparam int BW   = pcmq_pkg::ByteW;
    localparam int KW   = pcmq_pkg::KeyW;
    localparam int RW   = pcmq_pkg::RefW;

    typedef enum logic [14:0] {
        S_CLEAR   = 15'h0001,
        S_IDLE    = 15'h0002,
        S_CSCAN   = 15'h0004,
        S_ACT     = 15'h0008,
        S_OSCAN   = 15'h0010,
        S_CLOSE2  = 15'h0020,
        S_SUBOLD  = 15'h0040,
        S_ADD     = 15'h0080,
        S_LIM     = 15'h0100,
        S_DEC     = 15'h0200,
        S_RESTORE = 15'h0400,
        S_UOBJ    = 15'h0800,
        S_UNC     = 15'h1000,
        S_CWR     = 15'h2000,
        S_DONE    = 15'h4000
    } t_state;

    t_state r_state;
    logic [SW-1:0] r_cnt, r_pcnt;
    logic r_pend, r_drop, r_cfg;
    pcmq_pkg::t_action r_action;
    logic [21:0] r_gid;
    logic [7:0]  r_minor;
    logic [31:0] r_handle;
    logic [BW-1:0] r_amt, r_lim;
    logic r_trial, r_bad;
    logic [CONTEXT_SLOTS-1:0] r_cvalid;
    logic r_cfound, r_cfree_ok;
    logic [CIW-1:0] r_cidx, r_cfree;
    logic [RW-1:0] r_refs;
    logic [BW-1:0] r_used, r_acc, r_sum, r_old, r_sub, r_rel;
    logic r_ovf, r_over;
    logic r_ofound, r_ofree_ok;
    logic [OIW-1:0] r_oidx, r_ofree;
    pcmq_pkg::t_status r_status;
    logic r_deny;
    logic r_out_valid, r_out_deny;
    pcmq_pkg::t_status r_out_status;
    logic [BW-1:0] r_out_rel, r_out_used;

    logic [KW-1:0] w_key;
    logic [pcmq_pkg::OKeyW-1:0] w_okey;
    logic [pcmq_pkg::CtxW-1:0] w_ctx_rdata, w_ctx_wdata;
    logic [pcmq_pkg::ObjW-1:0] w_obj_rdata, w_obj_wdata;
    logic w_ctx_we, w_obj_we;
    logic [OIW-1:0] w_obj_waddr;
    logic w_o_valid, w_o_hit, w_drop_hit, w_c_hit, w_stop;
    logic [pcmq_pkg::OKeyW-1:0] w_o_key;
    logic [RW-1:0] w_eff_refs, w_close_refs;
    logic [BW-1:0] w_eff_used;
    pcmq_pkg::t_status w_dec_status;
    pcmq_pkg::t_alu_req w_alu_req;
    pcmq_pkg::t_alu_rsp w_alu_rsp;
    logic w_s_fire;
    logic [2:0] w_in_act;
    logic [BW-1:0] w_in_amt;
    logic [31:0] w_in_handle;

    assign w_key  = {r_gid, r_minor};
    assign w_okey = {w_key, r_handle};
    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_fire   = i_s_tvalid && o_s_tready;
    assign w_in_act    = i_s_tuser[2:0];
    assign w_in_handle = i_s_tdata[62:31];
    assign w_in_amt    = i_s_tdata[126:63];

    assign w_c_hit   = r_cvalid[r_pcnt[CIW-1:0]] && (w_ctx_rdata[pcmq_pkg::CtxW-1 -: KW] == w_key);
    assign w_o_valid = w_obj_rdata[pcmq_pkg::ObjW-1];
    assign w_o_key   = w_obj_rdata[pcmq_pkg::ObjW-2 -: pcmq_pkg::OKeyW];
    assign w_o_hit   = w_o_valid && (w_o_key == w_okey);
    assign w_drop_hit = w_o_valid && (w_o_key[pcmq_pkg::OKeyW-1 -: KW] == w_key);
    assign w_stop    = r_ovf || (r_over && !r_trial);

    assign w_eff_refs   = r_cfound ? r_refs : '0;
    assign w_eff_used   = r_cfound ? r_used : '0;
    assign w_close_refs = (r_refs == '0) ? '0 : r_refs - RW'(1);

    assign w_dec_status = r_ovf  ? pcmq_pkg::ST_OVERFLOW :
                          r_over ? (r_trial ? pcmq_pkg::ST_TRIAL : pcmq_pkg::ST_QUOTA) :
                                   r_status;

    pcmq_ram #(.WIDTH(pcmq_pkg::CtxW), .DEPTH(CONTEXT_SLOTS)) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctx_we),
        .i_waddr (r_cidx),
        .i_wdata (w_ctx_wdata),
        .i_raddr (r_cnt[CIW-1:0]),
        .o_rdata (w_ctx_rdata)
    );

    pcmq_ram #(.WIDTH(pcmq_pkg::ObjW), .DEPTH(OBJECT_SLOTS)) u_obj_ram (
        .i_clk   (i_clk),
        .i_we    (w_obj_we),
        .i_waddr (w_obj_waddr),
        .i_wdata (w_obj_wdata),
        .i_raddr (r_cnt[OIW-1:0]),
        .o_rdata (w_obj_rdata)
    );

    pcmq_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign w_ctx_we    = (r_state == S_CWR);
    assign w_ctx_wdata = {w_key, r_refs, r_used};

    always_comb begin
        w_alu_req = '0;
        unique case (r_state)
            S_SUBOLD:  w_alu_req = '{a: r_acc,  b: r_old, sub: 1'b1};
            S_ADD:     w_alu_req = '{a: r_acc,  b: r_amt, sub: 1'b0};
            S_LIM:     w_alu_req = '{a: r_lim,  b: r_sum, sub: 1'b1};
            S_RESTORE: w_alu_req = '{a: r_acc,  b: r_old, sub: 1'b0};
            S_UNC:     w_alu_req = '{a: r_used, b: r_sub, sub: 1'b1};
            default:   w_alu_req = '0;
        endcase
    end

    always_comb begin
        w_obj_we    = 1'b0;
        w_obj_waddr = r_pcnt[OIW-1:0];
        w_obj_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_obj_we    = 1'b1;
                w_obj_waddr = r_cnt[OIW-1:0];
            end
            S_OSCAN: begin
                // invalidate the context's objects on a last close with clear_on_last_close set
                w_obj_we = r_pend && r_drop && w_drop_hit;
            end
            S_DEC: begin
                w_obj_we    = (r_action == pcmq_pkg::ACT_COBJ) && !w_stop
                            && (r_ofound || r_ofree_ok);
                w_obj_waddr = r_ofound ? r_oidx : r_ofree;
                w_obj_wdata = {1'b1, w_okey, r_amt};
            end
            S_UOBJ: begin
                w_obj_we    = r_ofound && r_cfound;
                w_obj_waddr = r_oidx;
            end
            default: w_obj_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_cfg       <= 1'b1;
            r_cvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_cfg <= i_cfg_wdata;
            end
            if (r_out_valid && i_m_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt == SW'(OBJECT_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + SW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_s_fire) begin
                        r_action   <= pcmq_pkg::t_action'(w_in_act);
                        r_gid      <= i_s_tdata[21:0];
                        r_minor    <= i_s_tdata[29:22];
                        r_handle   <= w_in_handle;
                        r_amt      <= w_in_amt;
                        r_lim      <= i_s_tdata[190:127];
                        r_trial    <= i_s_tuser[3];
                        r_bad      <= (w_in_act > 3'd5)
                                   || ((w_in_act == pcmq_pkg::ACT_COBJ
                                        || w_in_act == pcmq_pkg::ACT_UOBJ)
                                       && w_in_handle == '0)
                                   || ((w_in_act == pcmq_pkg::ACT_CHARGE
                                        || w_in_act == pcmq_pkg::ACT_UNCH)
                                       && w_in_amt == '0);
                        r_cfound   <= 1'b0;
                        r_cfree_ok <= 1'b0;
                        r_deny     <= 1'b0;
                        r_rel      <= '0;
                        r_cnt      <= '0;
                        r_pend     <= 1'b0;
                        if (i_s_tdata[21:0] != '0 && !i_s_tdata[30]) begin
                            r_status <= pcmq_pkg::ST_OK;
                            r_state  <= S_CSCAN;
                        end else begin
                            r_status <= pcmq_pkg::ST_INVALID;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_CSCAN: begin
                    if (r_cnt != SW'(CONTEXT_SLOTS)) begin
                        r_cnt  <= r_cnt + SW'(1);
                        r_pcnt <= r_cnt;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (w_c_hit && !r_cfound) begin
                            r_cfound <= 1'b1;
                            r_cidx   <= r_pcnt[CIW-1:0];
                            r_refs   <= w_ctx_rdata[BW +: RW];
                            r_used   <= w_ctx_rdata[BW-1:0];
                        end
                        if (!r_cvalid[r_pcnt[CIW-1:0]] && !r_cfree_ok) begin
                            r_cfree_ok <= 1'b1;
                            r_cfree    <= r_pcnt[CIW-1:0];
                        end
                        if (r_pcnt == SW'(CONTEXT_SLOTS - 1)) begin
                            r_state <= S_ACT;
                        end
                    end
                end
                S_ACT: begin
                    r_cnt      <= '0;
                    r_pend     <= 1'b0;
                    r_drop     <= 1'b0;
                    r_ofound   <= 1'b0;
                    r_ofree_ok <= 1'b0;
                    r_old      <= '0;
                    if (r_bad) begin
                        r_status <= pcmq_pkg::ST_INVALID;
                        r_state  <= S_DONE;
                    end else begin
                        unique case (r_action)
                            pcmq_pkg::ACT_OPEN, pcmq_pkg::ACT_CHARGE,
                            pcmq_pkg::ACT_COBJ: begin
                                if (!r_cfound && !r_cfree_ok) begin
                                    r_status <= pcmq_pkg::ST_CTX_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    if (!r_cfound) begin
                                        r_cfound          <= 1'b1;
                                        r_cidx            <= r_cfree;
                                        r_cvalid[r_cfree] <= 1'b1;
                                    end
                                    r_used <= w_eff_used;
                                    r_acc  <= w_eff_used;
                                    // saturate the reference count on open
                                    r_refs <= (r_action == pcmq_pkg::ACT_OPEN
                                               && w_eff_refs != pcmq_pkg::RefMax)
                                            ? w_eff_refs + RW'(1) : w_eff_refs;
                                    if (r_action == pcmq_pkg::ACT_OPEN) begin
                                        r_state <= S_CWR;
                                    end else if (r_action == pcmq_pkg::ACT_CHARGE) begin
                                        r_state <= S_ADD;
                                    end else begin
                                        r_state <= S_OSCAN;
                                    end
                                end
                            end
                            pcmq_pkg::ACT_CLOSE: begin
                                if (!r_cfound) begin
                                    r_status <= pcmq_pkg::ST_NOT_FOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_refs <= w_close_refs;
                                    if (w_close_refs == '0 && r_cfg) begin
                                        r_used  <= '0;
                                        r_drop  <= 1'b1;
                                        r_state <= S_OSCAN;
                                    end else begin
                                        r_state <= S_CLOSE2;
                                    end
                                end
                            end
                            pcmq_pkg::ACT_UNCH: begin
                                if (!r_cfound) begin
                                    r_status <= pcmq_pkg::ST_NOT_FOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_sub   <= r_amt;
                                    r_state <= S_UNC;
                                end
                            end
                            pcmq_pkg::ACT_UOBJ: r_state <= S_OSCAN;
                            default: begin
                                r_status <= pcmq_pkg::ST_INVALID;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_OSCAN: begin
                    if (r_cnt != SW'(OBJECT_SLOTS)) begin
                        r_cnt  <= r_cnt + SW'(1);
                        r_pcnt <= r_cnt;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (w_o_hit && !r_ofound) begin
                            r_ofound <= 1'b1;
                            r_oidx   <= r_pcnt[OIW-1:0];
                            r_old    <= w_obj_rdata[BW-1:0];
                        end
                        if (!w_o_valid && !r_ofree_ok) begin
                            r_ofree_ok <= 1'b1;
                            r_ofree    <= r_pcnt[OIW-1:0];
                        end
                        if (r_pcnt == SW'(OBJECT_SLOTS - 1)) begin
                            priority if (r_action == pcmq_pkg::ACT_CLOSE) begin
                                r_state <= S_CLOSE2;
                            end else if (r_action == pcmq_pkg::ACT_COBJ) begin
                                r_state <= S_SUBOLD;
                            end else begin
                                r_state <= S_UOBJ;
                            end
                        end
                    end
                end
                S_CLOSE2: begin
                    // free a context left with no references and no bytes
                    if (r_refs == '0 && r_used == '0) begin
                        r_cvalid[r_cidx] <= 1'b0;
                        r_cfound         <= 1'b0;
                    end
                    r_state <= S_CWR;
                end
                S_SUBOLD: begin
                    r_acc   <= w_alu_rsp.cout ? '0 : w_alu_rsp.res;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum   <= w_alu_rsp.res;
                    r_ovf   <= w_alu_rsp.cout;
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    r_over  <= (r_lim != '0) && w_alu_rsp.cout;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_deny <= r_ovf || r_over;
                    if (r_action == pcmq_pkg::ACT_CHARGE) begin
                        if (!w_stop) begin
                            r_used <= r_sum;
                        end
                        r_status <= w_dec_status;
                        r_state  <= S_CWR;
                    end else if (w_stop) begin
                        r_status <= w_dec_status;
                        r_state  <= S_RESTORE;
                    end else if (!r_ofound && !r_ofree_ok) begin
                        r_status <= pcmq_pkg::ST_OBJ_FULL;
                        r_used   <= r_acc;
                        r_state  <= S_CWR;
                    end else begin
                        r_status <= w_dec_status;
                        r_used   <= r_sum;
                        r_state  <= S_CWR;
                    end
                end
                S_RESTORE: begin
                    // put the replaced object's size back
                    r_used  <= w_alu_rsp.res;
                    r_state <= S_CWR;
                end
                S_UOBJ: begin
                    if (!r_ofound || !r_cfound) begin
                        r_status <= pcmq_pkg::ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_rel   <= r_old;
                        r_sub   <= r_old;
                        r_state <= S_UNC;
                    end
                end
                S_UNC: begin
                    if (w_alu_rsp.cout) begin
                        r_used   <= '0;
                        r_status <= pcmq_pkg::ST_CLAMPED;
                    end else begin
                        r_used <= w_alu_rsp.res;
                    end
                    r_state <= S_CWR;
                end
                S_CWR: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_deny   <= r_deny;
                        r_out_rel    <= r_rel;
                        r_out_used   <= r_cfound ? r_used : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_used, r_out_rel};
    assign o_m_tuser  = {r_out_deny, r_out_status};

    `PCMQ_ASSERT(a_no_req_in_clear, !((r_state == S_CLEAR) && o_s_tready))
    `PCMQ_ASSERT_NEXT(a_busy_after_req, w_s_fire, !o_s_tready)
    `PCMQ_ASSERT(a_deny_status, !(r_out_valid && r_out_deny) || r_out_status == pcmq_pkg::ST_TRIAL || r_out_status == pcmq_pkg::ST_OVERFLOW || r_out_status == pcmq_pkg::ST_QUOTA || r_out_status == pcmq_pkg::ST_OBJ_FULL)
    `PCMQ_ASSERT(a_release_status, !(r_out_valid && r_out_rel != '0) || r_out_status == pcmq_pkg::ST_OK || r_out_status == pcmq_pkg::ST_CLAMPED)
endmodule

FILE: hdl/pcmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hdl/pcmq_alu.sv
// Shared 64-bit add/subtract unit with carry and borrow out.
module pcmq_alu (
    input  pcmq_pkg::t_alu_req i_req,
    output pcmq_pkg::t_alu_rsp o_rsp
);
    logic [pcmq_pkg::ByteW:0] w_sum;

    assign w_sum = {1'b0, i_req.a}
                 + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
                 + {{pcmq_pkg::ByteW{1'b0}}, i_req.sub};
    assign o_rsp.res  = w_sum[pcmq_pkg::ByteW-1:0];
    assign o_rsp.cout = i_req.sub ? ~w_sum[pcmq_pkg::ByteW] : w_sum[pcmq_pkg::ByteW];
endmodule
